FILE: sv/nbhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbhc_pkg
// Types and constants shared by the named bundle header checker modules.
// ----------------------------------------------------------------------------
package nbhc_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned NAME_LEN_W = 9;
   localparam int unsigned PAY_LEN_W  = 32;
   localparam int unsigned COUNT_W    = 33;
   localparam int unsigned CAP_W      = 9;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 56;
   localparam int unsigned RSP_USER_W = 2;

   // length field occupies the first four bytes
   localparam logic [COUNT_W-1:0] LEN_FIELD_BYTES = 33'd4;
   // old count at which the new count reaches the minimum bundle size
   localparam logic [COUNT_W-1:0] MIN_BUNDLE_PREV = 33'd5;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

   localparam logic [BYTE_W-1:0] SEP_CHAR       = 8'h0A;
   localparam logic [BYTE_W-1:0] SLASH_CHAR     = 8'h2F;
   localparam logic [BYTE_W-1:0] BACKSLASH_CHAR = 8'h5C;
   localparam logic [BYTE_W-1:0] DOT_CHAR       = 8'h2E;
   localparam logic [BYTE_W-1:0] NUL_CHAR       = 8'h00;

   typedef enum logic [1:0] {
      ROLE_LENGTH  = 2'd0,
      ROLE_NAME    = 2'd1,
      ROLE_SEP     = 2'd2,
      ROLE_PAYLOAD = 2'd3
   } role_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              is_last;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     byte_out;
      role_type              role;
      logic                  end_of_bundle;
      logic                  bundle_ok;
      logic [NAME_LEN_W-1:0] name_length;
      logic [PAY_LEN_W-1:0]  payload_length;
   } result_type;

endpackage

FILE: sv/nbhc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbhc_in_stage
// Input register: captures one byte transaction from the request stream.
// ----------------------------------------------------------------------------
module nbhc_in_stage
   import nbhc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  item_valid,
   input  logic                  item_take,
   output item_type              item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || item_take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.data_byte <= req_tdata[BYTE_W-1:0];
         item_ff.is_last   <= req_tlast;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: sv/nbhc_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbhc_parse
// Bundle state, byte role tagging and the end-of-bundle verdict.
// ----------------------------------------------------------------------------
module nbhc_parse
   import nbhc_pkg::*;
#(
   parameter int unsigned NAME_LIMIT = 255
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   input  logic             take,
   input  item_type         item,
   output result_type       result
);

   localparam logic [NAME_LEN_W-1:0] NameMax   = NAME_LEN_W'(NAME_LIMIT + 1);
   localparam logic [NAME_LEN_W-1:0] NameLimit = NAME_LEN_W'(NAME_LIMIT);

   logic [PAY_LEN_W-1:0]  length_ff,  length_in;
   logic [COUNT_W-1:0]    count_ff,   count_in;
   logic [NAME_LEN_W-1:0] name_ff,    name_in;
   logic [PAY_LEN_W-1:0]  pay_ff,     pay_in;
   logic                  sep_ff,     sep_in;
   logic                  bad_ff,     bad_in;
   logic                  dot1_ff,    dot1_in;
   logic                  dot2_ff,    dot2_in;
   logic [CAP_W-1:0]      cap_ff;
   role_type              role;
   logic                  ok;
   logic                  len_match;

   // body+4 == new count, checked against the count before this byte
   assign len_match = ({1'b0, length_ff} + 33'd3) == count_ff;

   always_comb begin
      length_in = length_ff;
      name_in   = name_ff;
      pay_in    = pay_ff;
      sep_in    = sep_ff;
      bad_in    = bad_ff;
      dot1_in   = dot1_ff;
      dot2_in   = dot2_ff;
      role      = ROLE_PAYLOAD;

      if (count_ff < LEN_FIELD_BYTES) begin
         role = ROLE_LENGTH;
         length_in[8*count_ff[1:0] +: 8] = item.data_byte;
      end else if (!sep_ff) begin
         if (item.data_byte == SEP_CHAR) begin
            role   = ROLE_SEP;
            sep_in = 1'b1;
         end else begin
            role = ROLE_NAME;
            if (item.data_byte == SLASH_CHAR || item.data_byte == BACKSLASH_CHAR
                || item.data_byte == NUL_CHAR) begin
               bad_in = 1'b1;
            end
            if (name_ff == 9'd0 && item.data_byte == DOT_CHAR) begin
               dot1_in = 1'b1;
            end
            if (name_ff == 9'd1 && item.data_byte == DOT_CHAR) begin
               dot2_in = 1'b1;
            end
            if (name_ff < NameMax) begin
               name_in = name_ff + 9'd1;
            end
         end
      end else begin
         pay_in = pay_ff + 32'd1;
      end

      count_in = (count_ff != COUNT_MAX) ? count_ff + 33'd1 : count_ff;

      ok = item.is_last;
      if (count_ff < MIN_BUNDLE_PREV) ok = 1'b0;
      if (!len_match) ok = 1'b0;
      if (!sep_in) ok = 1'b0;
      if (name_in == 9'd0 || name_in > NameLimit) ok = 1'b0;
      if (bad_in) ok = 1'b0;
      if (dot1_in && (name_in == 9'd1 || (name_in == 9'd2 && dot2_in))) ok = 1'b0;
      if (cap_ff != 9'd0 && name_in >= cap_ff) ok = 1'b0;

      result.byte_out       = item.data_byte;
      result.role           = role;
      result.end_of_bundle  = item.is_last;
      result.bundle_ok      = ok;
      result.name_length    = name_in;
      // payload bytes counted equal body - name - 1 whenever the bundle passes
      result.payload_length = ok ? pay_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         count_ff  <= '0;
         name_ff   <= '0;
         pay_ff    <= '0;
         sep_ff    <= 1'b0;
         bad_ff    <= 1'b0;
         dot1_ff   <= 1'b0;
         dot2_ff   <= 1'b0;
      end else if (take) begin
         if (item.is_last) begin
            length_ff <= '0;
            count_ff  <= '0;
            name_ff   <= '0;
            pay_ff    <= '0;
            sep_ff    <= 1'b0;
            bad_ff    <= 1'b0;
            dot1_ff   <= 1'b0;
            dot2_ff   <= 1'b0;
         end else begin
            length_ff <= length_in;
            count_ff  <= count_in;
            name_ff   <= name_in;
            pay_ff    <= pay_in;
            sep_ff    <= sep_in;
            bad_ff    <= bad_in;
            dot1_ff   <= dot1_in;
            dot2_ff   <= dot2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      take && item.is_last |=> count_ff == '0 && name_ff == '0 && !sep_ff)
      else $error("bundle state not cleared after final byte");

   assert property (@(posedge clock) disable iff (reset)
      name_ff <= NameMax)
      else $error("name count above saturation limit");

   assert property (@(posedge clock) disable iff (reset)
      sep_ff |-> count_ff >= MIN_BUNDLE_PREV)
      else $error("separator seen before length field and name byte");

   assert property (@(posedge clock) disable iff (reset)
      pay_ff != '0 |-> sep_ff)
      else $error("payload counted without separator");

endmodule

FILE: sv/nbhc_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbhc_out_stage
// Result register: holds one result and drives the response stream.
// ----------------------------------------------------------------------------
module nbhc_out_stage
   import nbhc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   output logic                  res_ready,
   input  result_type            result,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign res_ready = !valid_ff || rsp_tready;
   assign valid_in  = (res_valid && res_ready) || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, result_ff.payload_length, result_ff.name_length,
                        result_ff.bundle_ok, result_ff.byte_out};
   assign rsp_tuser  = result_ff.role;
   assign rsp_tlast  = result_ff.end_of_bundle;

endmodule

FILE: sv/named_bundle_header_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// named_bundle_header_checker
// Checks a byte stream bundle (length field, file name, newline, payload),
// tags each byte with its role and gives a verdict on the final byte.
//
//   channel   dir  handshake          payload
//   req_      in   tvalid/tready      tdata[7:0] data byte, tlast final byte
//   rsp_      out  tvalid/tready      tdata, tuser role, tlast end of bundle
//   csr_      in   wr_en              wr_data name capacity (9 bits)
//
// One byte per cycle while rsp_tready is high; each byte goes input register ->
// result register, two register stages from request to response.
// Reset clears both stages, the bundle state and the capacity register.
// With rsp_tready low the result holds and the input register, if empty,
// takes one more byte before req_tready drops.
// ----------------------------------------------------------------------------
module named_bundle_header_checker
   import nbhc_pkg::*;
#(
   parameter int unsigned NAME_LIMIT = 255
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] byte_out, [8] bundle_ok, [17:9] name_length,
   // [49:18] payload_length, [55:50] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [1:0] role
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CAP_W-1:0]      csr_wr_data
);

   logic       item_valid;
   logic       res_ready;
   logic       take;
   item_type   item;
   result_type result;

   // transaction moves from input register to result register
   assign take = item_valid && res_ready;

   nbhc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item_take  (take),
      .item       (item)
   );

   nbhc_parse #(
      .NAME_LIMIT (NAME_LIMIT)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .item        (item),
      .result      (result)
   );

   nbhc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (item_valid),
      .res_ready  (res_ready),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for named_bundle_header_checker. A short table of
// hand-made bundles comes first, then random bundles under several name
// capacity settings. Every byte is predicted on acceptance and each
// response is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import nbhc_pkg::*;

   localparam int NAME_MAX     = 255;
   localparam int MIN_BUNDLE   = 6;
   localparam int PHASE_ITEMS  = 10;
   localparam int PIPE_SETTLE  = 6;
   localparam int DIRECTED_N   = 28;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
      logic       typed;
      result_type want;
   } step_row_type;

   localparam result_type NONE = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CAP_W-1:0]      csr_wr_data = '0;

   // predictor state
   logic [31:0]           len_acc = '0;
   logic [COUNT_W-1:0]    byte_cnt = '0;
   logic [NAME_LEN_W-1:0] name_cnt = '0;
   logic                  sep_seen = 1'b0;
   logic                  bad_name = 1'b0;
   logic                  dot_first = 1'b0;
   logic                  dot_second = 1'b0;
   logic [CAP_W-1:0]      capacity = '0;

   result_type            tagged_q[$];
   step_row_type          directed_rows [DIRECTED_N];
   logic                  pending_typed = 1'b0;
   result_type            pending_want = '0;
   logic                  send_gaps = 1'b1;
   logic                  stall_on = 1'b1;
   int                    items_sent = 0;
   int                    errors = 0;
   int                    responses_seen = 0;
   int                    bundles_closed = 0;
   int                    bundles_accepted = 0;

   named_bundle_header_checker #(.NAME_LIMIT(NAME_MAX)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // tags one byte and advances the bundle state
   function automatic result_type predict_tag(input logic [7:0] b, input logic last);
      result_type r;
      logic       ok;
      r = '0;
      if (byte_cnt < LEN_FIELD_BYTES) begin
         r.role = ROLE_LENGTH;
         len_acc = len_acc | (32'(b) << (8 * byte_cnt[1:0]));
      end else if (!sep_seen) begin
         if (b == SEP_CHAR) begin
            r.role = ROLE_SEP;
            sep_seen = 1'b1;
         end else begin
            r.role = ROLE_NAME;
            if (b == SLASH_CHAR || b == BACKSLASH_CHAR || b == NUL_CHAR) bad_name = 1'b1;
            if (name_cnt == 0 && b == DOT_CHAR) dot_first = 1'b1;
            if (name_cnt == 1 && b == DOT_CHAR) dot_second = 1'b1;
            if (name_cnt < NAME_MAX + 1) name_cnt = name_cnt + 1'b1;
         end
      end else begin
         r.role = ROLE_PAYLOAD;
      end
      if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + 1'b1;
      r.byte_out = b;
      r.end_of_bundle = last;
      r.name_length = name_cnt;
      if (last) begin
         ok = 1'b1;
         if (byte_cnt < MIN_BUNDLE) ok = 1'b0;
         if ({1'b0, len_acc} + 33'd4 != byte_cnt) ok = 1'b0;
         if (!sep_seen) ok = 1'b0;
         if (name_cnt == 0 || name_cnt > NAME_MAX) ok = 1'b0;
         if (bad_name) ok = 1'b0;
         if (dot_first && (name_cnt == 1 || (name_cnt == 2 && dot_second))) ok = 1'b0;
         if (capacity != 0 && ({1'b0, name_cnt} + 10'd1) > {1'b0, capacity}) ok = 1'b0;
         r.bundle_ok = ok;
         if (ok) r.payload_length = len_acc - 32'(name_cnt) - 32'd1;
         len_acc = '0;
         byte_cnt = '0;
         name_cnt = '0;
         sep_seen = 1'b0;
         bad_name = 1'b0;
         dot_first = 1'b0;
         dot_second = 1'b0;
      end
      return r;
   endfunction

   always @(negedge clock) begin
      rsp_tready <= stall_on ? ($urandom_range(99) >= 38) : 1'b1;
   end

   always @(posedge clock) begin : track_requests
      result_type guess;
      if (!reset && req_tvalid && req_tready) begin
         guess = predict_tag(req_tdata, req_tlast);
         tagged_q.push_back(pending_typed ? pending_want : guess);
      end
   end

   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tagged_q.size() == 0) begin
            report_mismatch("transaction with no expected result");
         end else begin
            want = tagged_q.pop_front();
            if (rsp_tdata[7:0] !== want.byte_out)
               report_mismatch($sformatf("byte_out got %0h want %0h",
                                         rsp_tdata[7:0], want.byte_out));
            if (rsp_tuser !== want.role)
               report_mismatch($sformatf("role got %0d want %0d", rsp_tuser, want.role));
            if (rsp_tlast !== want.end_of_bundle)
               report_mismatch($sformatf("end_of_bundle got %0b want %0b",
                                         rsp_tlast, want.end_of_bundle));
            if (rsp_tdata[8] !== want.bundle_ok)
               report_mismatch($sformatf("bundle_ok got %0b want %0b",
                                         rsp_tdata[8], want.bundle_ok));
            if (rsp_tdata[17:9] !== want.name_length)
               report_mismatch($sformatf("name_length got %0d want %0d",
                                         rsp_tdata[17:9], want.name_length));
            if (rsp_tdata[49:18] !== want.payload_length)
               report_mismatch($sformatf("payload_length got %0d want %0d",
                                         rsp_tdata[49:18], want.payload_length));
            responses_seen++;
            if (rsp_tlast) bundles_closed++;
            if (rsp_tlast && rsp_tdata[8]) bundles_accepted++;
         end
      end
   end

   // returns at the rising edge where the transaction was taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while (send_gaps && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain_results;
      int guard;
      guard = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tagged_q.size() != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      if (tagged_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived", tagged_q.size()));
         tagged_q.delete();
      end
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   task automatic set_capacity(input int cap);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap[CAP_W-1:0];
      capacity = cap[CAP_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] name_char();
      int         r;
      logic [7:0] c;
      r = $urandom_range(199);
      c = 8'($urandom);
      if (c == SEP_CHAR) c = 8'h41;
      if (r == 0) c = SLASH_CHAR;
      else if (r == 1) c = BACKSLASH_CHAR;
      else if (r == 2) c = NUL_CHAR;
      else if (r < 20) c = DOT_CHAR;
      return c;
   endfunction

   // forced_name < 0 picks a random shape, otherwise a clean bundle with
   // a name of that many bytes
   task automatic gen_bundle(input int forced_name);
      logic [7:0]  bq[$];
      logic [31:0] body;
      int          nlen;
      int          plen;
      int          pick;
      logic        drop_sep;
      logic        dot_mode;
      pick = $urandom_range(99);
      drop_sep = 1'b0;
      dot_mode = 1'b0;
      if (forced_name < 0 && pick < 12) begin
         // noise: random bytes, often ending inside the length field
         repeat ($urandom_range(1, 12)) bq.push_back(8'($urandom));
      end else begin
         if (forced_name >= 0) begin
            nlen = forced_name;
         end else begin
            pick = $urandom_range(99);
            if (pick < 6) begin
               nlen = 0;
            end else if (pick < 16) begin
               nlen = $urandom_range(1, 3);
               dot_mode = 1'b1;
            end else begin
               nlen = $urandom_range(1, 12);
            end
            drop_sep = ($urandom_range(99) < 5);
         end
         plen = $urandom_range(0, 10);
         body = 32'(nlen + 1 + plen);
         if (forced_name < 0) begin
            pick = $urandom_range(99);
            if (pick < 5) body = body + 32'($urandom_range(1, 3));
            else if (pick < 9) body = body - 32'd1;
            else if (pick < 12) body = $urandom;
         end
         for (int i = 0; i < 4; i++) bq.push_back(body[8*i +: 8]);
         for (int i = 0; i < nlen; i++) begin
            if (dot_mode) bq.push_back(($urandom_range(99) < 70) ? DOT_CHAR : 8'h78);
            else if (forced_name >= 0) bq.push_back(8'h61 + 8'(i % 26));
            else bq.push_back(name_char());
         end
         if (!drop_sep) bq.push_back(SEP_CHAR);
         for (int i = 0; i < plen; i++)
            bq.push_back(($urandom_range(99) < 10) ? SEP_CHAR : 8'($urandom));
      end
      for (int i = 0; i < bq.size(); i++) send_byte(bq[i], i == bq.size() - 1);
   endtask

   task automatic run_phase(input int cap, input int long_name);
      int first;
      if (cap >= 0) set_capacity(cap);
      if (long_name > 0) gen_bundle(long_name);
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) gen_bundle(-1);
      drain_results();
   endtask

   initial begin
      directed_rows = '{
         // minimal good bundle, name "a", empty payload
         '{8'h02, 1'b0, 1'b1, '{8'h02, ROLE_LENGTH, 1'b0, 1'b0, 9'd0, 32'd0}},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h61, 1'b0, 1'b0, NONE},
         '{8'h0A, 1'b1, 1'b1, '{8'h0A, ROLE_SEP, 1'b1, 1'b1, 9'd1, 32'd0}},
         // ends inside the length field
         '{8'hFF, 1'b1, 1'b1, '{8'hFF, ROLE_LENGTH, 1'b1, 1'b0, 9'd0, 32'd0}},
         // name "..", newline inside the payload
         '{8'h05, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h2E, 1'b0, 1'b0, NONE},
         '{8'h2E, 1'b0, 1'b0, NONE},
         '{8'h0A, 1'b0, 1'b0, NONE},
         '{8'h0A, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b1, 1'b1, '{8'h00, ROLE_PAYLOAD, 1'b1, 1'b0, 9'd2, 32'd0}},
         // backslash in the name
         '{8'h03, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h00, 1'b0, 1'b0, NONE},
         '{8'h5C, 1'b0, 1'b0, NONE},
         '{8'h0A, 1'b0, 1'b0, NONE},
         '{8'h41, 1'b1, 1'b1, '{8'h41, ROLE_PAYLOAD, 1'b1, 1'b0, 9'd1, 32'd0}},
         // all-ones length, empty name, too short
         '{8'hFF, 1'b0, 1'b0, NONE},
         '{8'hFF, 1'b0, 1'b0, NONE},
         '{8'hFF, 1'b0, 1'b0, NONE},
         '{8'hFF, 1'b0, 1'b0, NONE},
         '{8'h0A, 1'b1, 1'b1, '{8'h0A, ROLE_SEP, 1'b1, 1'b0, 9'd0, 32'd0}}
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // updated after the accepting edge so the tracker sees the row just sent
      for (int i = 0; i < DIRECTED_N; i++) begin
         pending_typed <= directed_rows[i].typed;
         pending_want <= directed_rows[i].want;
         send_byte(directed_rows[i].data_byte, directed_rows[i].is_last);
      end
      pending_typed <= 1'b0;
      drain_results();

      run_phase(-1, 0);
      run_phase(256, 0);
      run_phase(1, 0);
      run_phase(2, 0);
      run_phase(300, 258);
      run_phase(511, 0);
      run_phase($urandom_range(3, 40), 0);
      // final stretch at full rate on both sides
      send_gaps = 1'b0;
      stall_on = 1'b0;
      run_phase(0, 0);

      $display("checked %0d transactions, %0d bundles closed, %0d accepted",
               responses_seen, bundles_closed, bundles_accepted);
      $display("eight name capacity phases, throttled and full-rate traffic");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
